// ===== sv/drcrf_pkg.sv =====
// Shared types, constants and field-scramble functions for the DRAM chip register file.
// No dependencies; imported by every module of the block.
`default_nettype none

package drcrf_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_XLATE = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  // Chip register indexes
  localparam int unsigned  REG_IDX_W     = 4;
  localparam logic [3:0]   REG_DEV_TYPE  = 4'd0;
  localparam logic [3:0]   REG_ID        = 4'd1;
  localparam logic [3:0]   REG_DELAY     = 4'd2;
  localparam logic [3:0]   REG_MODE      = 4'd3;
  localparam logic [3:0]   REG_REF_INTV  = 4'd4;
  localparam logic [3:0]   REG_REF_ROW   = 4'd5;
  localparam logic [3:0]   REG_RAS_INTV  = 4'd6;
  localparam logic [3:0]   REG_MIN_INTV  = 4'd7;
  localparam logic [3:0]   REG_ADDR_SEL  = 4'd8;
  localparam logic [3:0]   REG_MAKER     = 4'd9;

  // Configuration port
  localparam int unsigned  CFG_IDX_W      = 2;
  localparam int unsigned  CFG_DATA_W     = 6;
  localparam logic [1:0]   CFG_CHIP_COUNT = 2'd0;
  localparam logic [1:0]   CFG_CC_HIGH    = 2'd1;
  localparam logic [2:0]   CHIP_COUNT_RST = 3'd2;
  localparam logic [5:0]   CC_HIGH_RST    = 6'd15;

  // Register constants
  localparam logic [31:0]  DEVICE_TYPE  = 32'hB419_0010;
  localparam logic [31:0]  DEVICE_MAKER = 32'h0000_0500;
  localparam logic [31:0]  DELAY_RESET  = 32'h0000_0023;
  localparam logic [31:0]  DELAY_MASK   = 32'h3838_1838;
  localparam logic [31:0]  DELAY_FIXED  = 32'h0303_0203;
  localparam logic [31:0]  CCI_BITS     = 32'h00C0_C0C0;
  localparam logic [31:0]  MODE_INVERT  = 32'hC0C0_C0C0;
  localparam logic [2:0]   WDELAY_DIRECT = 3'd1;
  localparam logic [7:0]   REPEAT_MIN    = 8'd16;

  localparam int unsigned  LOW_ADDR_W = 21;
  localparam int unsigned  PHYS_W     = 23;
  localparam int unsigned  CODE_W     = 6;
  localparam int unsigned  DEV_ID_W   = 16;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC,
    ST_IDENT,
    ST_DONE
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the item fields
    logic lookup;  // resolve chip, translate, clear results
    logic exec;    // perform read or write on the selected chip
    logic ident;   // refresh the identity-mapping flag
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ident_req;  // the write being executed touches a chip register
  } dp_status_t;

  // Device ID gathered from the scattered ID register bits
  function automatic logic [15:0] id_from_word(input logic [31:0] v);
    return {v[7], v[15:8], v[23], v[31:26]};
  endfunction

  // Current code from the inverted, scattered mode-word bits
  function automatic logic [5:0] code_from_mode(input logic [31:0] m);
    return {m[23], m[15], m[7], m[22], m[14], m[6]} ^ 6'h3F;
  endfunction

  // Mode-word bits carrying a current code
  function automatic logic [31:0] mode_from_code(input logic [5:0] c);
    logic [5:0]  ci;
    logic [31:0] r;
    ci    = ~c;
    r     = '0;
    r[6]  = ci[0];
    r[14] = ci[1];
    r[22] = ci[2];
    r[7]  = ci[3];
    r[15] = ci[4];
    r[23] = ci[5];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/drcrf_ctrl.sv =====
// Sequencing state machine of the DRAM chip register file.
// Depends on drcrf_pkg; drives drcrf_dp through dp_cmd_t.
`default_nettype none

module drcrf_ctrl import drcrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       result_valid_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    result_valid_o = 1'b0;
    busy_o         = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.ident_req ? ST_IDENT : ST_DONE;
      end
      ST_IDENT: begin
        cmd_o.ident = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        result_valid_o = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/drcrf_dp.sv =====
// Datapath of the DRAM chip register file: item capture, per-chip registers,
// chip search, address translate and result registers. Depends on drcrf_pkg.
`default_nettype none

module drcrf_dp import drcrf_pkg::*; #(
  parameter int unsigned NUM_CHIPS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [1:0]            mode_i,
  input  logic                  ri_active_i,
  input  logic [15:0]           chip_select_i,
  input  logic                  broadcast_i,
  input  logic [REG_IDX_W-1:0]  reg_index_i,
  input  logic [31:0]           write_data_i,
  input  logic [7:0]            repeat_length_i,
  input  logic [31:0]           bus_address_i,
  output logic [31:0]           read_data_o,
  output logic                  chip_hit_o,
  output logic [PHYS_W-1:0]     phys_offset_o,
  output logic                  translate_hit_o,
  output logic                  identity_mapped_o
);

  localparam int unsigned CHIP_W = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;

  // Item fields
  mode_e                 item_mode_q;
  logic                  active_q;
  logic [15:0]           sel_q;
  logic                  bcast_q;
  logic [REG_IDX_W-1:0]  idx_q;
  logic [31:0]           wdata_q;
  logic [7:0]            rep_q;
  logic [31:0]           addr_q;

  // Configuration
  logic [2:0]            chip_count_q;
  logic [CODE_W-1:0]     cc_high_q;

  // Per-chip registers
  logic                  en_q        [NUM_CHIPS];
  logic                  auto_q      [NUM_CHIPS];
  logic [31:0]           id_q        [NUM_CHIPS];
  logic [31:0]           delay_q     [NUM_CHIPS];
  logic [31:0]           mode_word_q [NUM_CHIPS];
  logic [CODE_W-1:0]     cc_q        [NUM_CHIPS];
  logic [CODE_W-1:0]     icode_q     [NUM_CHIPS];
  logic [31:0]           ref_intv_q  [NUM_CHIPS];
  logic [31:0]           ref_row_q   [NUM_CHIPS];
  logic [31:0]           ras_intv_q  [NUM_CHIPS];
  logic [31:0]           min_intv_q  [NUM_CHIPS];
  logic [31:0]           addr_sel_q  [NUM_CHIPS];
  logic                  ident_q;

  // Lookup results
  logic                  hit_q;
  logic [CHIP_W-1:0]     chip_idx_q;
  logic [31:0]           read_data_q;
  logic                  thit_q;
  logic [PHYS_W-1:0]     phys_q;

  logic [NUM_CHIPS-1:0]  present;
  logic [DEV_ID_W-1:0]   dev_id [NUM_CHIPS];
  logic                  find_hit, seen_off, xl_hit, ident_calc;
  logic [CHIP_W-1:0]     find_idx, xl_idx;

  logic [31:0]           rd_mode, rd_value, wr_data;
  logic [CODE_W-1:0]     rd_code, wr_code;
  logic                  wr_direct, wr_ok, wr_en;

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_mode_q <= mode_e'(mode_i);
      active_q    <= ri_active_i;
      sel_q       <= chip_select_i;
      bcast_q     <= broadcast_i;
      idx_q       <= reg_index_i;
      wdata_q     <= write_data_i;
      rep_q       <= repeat_length_i;
      addr_q      <= bus_address_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_count_q <= CHIP_COUNT_RST;
      cc_high_q    <= CC_HIGH_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_CHIP_COUNT) begin
        chip_count_q <= cfg_data_i[2:0];
      end else if (cfg_index_i == CFG_CC_HIGH) begin
        cc_high_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    for (int n = 0; n < NUM_CHIPS; n++) begin
      present[n] = 3'(n) < chip_count_q;
      dev_id[n]  = id_from_word(id_q[n]);
    end
  end

  // Chip search: first enabled match, or the first disabled chip if it matches
  always_comb begin
    find_hit = 1'b0;
    find_idx = '0;
    seen_off = 1'b0;
    for (int n = 0; n < NUM_CHIPS; n++) begin
      if (present[n] && !find_hit) begin
        if (en_q[n]) begin
          if (dev_id[n][15:1] == sel_q[15:1]) begin
            find_hit = 1'b1;
            find_idx = CHIP_W'(n);
          end
        end else if (!seen_off) begin
          seen_off = 1'b1;
          if (dev_id[n][15:1] == sel_q[15:1]) begin
            find_hit = 1'b1;
            find_idx = CHIP_W'(n);
          end
        end
      end
    end
    if (bcast_q || !active_q) begin
      find_hit = 1'b0;
    end
  end

  // Address translate: first present enabled chip whose ID pair matches
  always_comb begin
    xl_hit = 1'b0;
    xl_idx = '0;
    for (int n = 0; n < NUM_CHIPS; n++) begin
      if (!xl_hit && present[n] && en_q[n] &&
          dev_id[n][15:1] == 15'(addr_q[31:LOW_ADDR_W])) begin
        xl_hit = 1'b1;
        xl_idx = CHIP_W'(n);
      end
    end
    if (!active_q) begin
      xl_hit = 1'b0;
    end
  end

  // Register read of the selected chip
  always_comb begin
    rd_mode = mode_word_q[chip_idx_q];
    rd_code = auto_q[chip_idx_q] ? icode_q[chip_idx_q] : code_from_mode(rd_mode);
    unique case (idx_q)
      REG_DEV_TYPE: rd_value = DEVICE_TYPE;
      REG_ID:       rd_value = id_q[chip_idx_q];
      REG_DELAY:    rd_value = delay_q[chip_idx_q] | DELAY_FIXED;
      REG_MODE:     rd_value = ((rd_mode & ~CCI_BITS) | mode_from_code(rd_code)) ^ MODE_INVERT;
      REG_REF_INTV: rd_value = ref_intv_q[chip_idx_q];
      REG_REF_ROW:  rd_value = ref_row_q[chip_idx_q];
      REG_RAS_INTV: rd_value = ras_intv_q[chip_idx_q];
      REG_MIN_INTV: rd_value = min_intv_q[chip_idx_q];
      REG_ADDR_SEL: rd_value = addr_sel_q[chip_idx_q];
      REG_MAKER:    rd_value = DEVICE_MAKER;
      default:      rd_value = '0;
    endcase
    if (!en_q[chip_idx_q]) begin
      rd_value = '0;
    end
  end

  // Write gating: with a write delay other than one, drop short bursts, swap halves otherwise
  always_comb begin
    wr_direct = delay_q[chip_idx_q][5:3] == WDELAY_DIRECT;
    wr_ok     = wr_direct || (rep_q >= REPEAT_MIN);
    wr_data   = wr_direct ? wdata_q : {wdata_q[15:0], wdata_q[31:16]};
    wr_code   = code_from_mode(wr_data);
    wr_en     = cmd_i.exec && item_mode_q == MODE_WRITE && hit_q && wr_ok;
    status_o.ident_req = item_mode_q == MODE_WRITE && hit_q && wr_ok &&
                         idx_q >= REG_ID && idx_q <= REG_ADDR_SEL;
  end

  always_comb begin
    ident_calc = 1'b1;
    for (int n = 0; n < NUM_CHIPS; n++) begin
      if (present[n] && !(en_q[n] && dev_id[n] == DEV_ID_W'(2 * n) &&
                          cc_q[n] >= cc_high_q)) begin
        ident_calc = 1'b0;
      end
    end
  end

  // Per-chip register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NUM_CHIPS; n++) begin
        en_q[n]        <= 1'b0;
        auto_q[n]      <= 1'b0;
        id_q[n]        <= '0;
        delay_q[n]     <= DELAY_RESET;
        mode_word_q[n] <= '0;
        cc_q[n]        <= '0;
        icode_q[n]     <= '0;
        ref_intv_q[n]  <= '0;
        ref_row_q[n]   <= '0;
        ras_intv_q[n]  <= '0;
        min_intv_q[n]  <= '0;
        addr_sel_q[n]  <= '0;
      end
      ident_q <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (idx_q)
          REG_ID:       id_q[chip_idx_q] <= wr_data;
          REG_DELAY:    delay_q[chip_idx_q] <= wr_data & DELAY_MASK;
          REG_MODE: begin
            mode_word_q[chip_idx_q] <= wr_data;
            en_q[chip_idx_q]        <= wr_data[25];
            auto_q[chip_idx_q]      <= wr_data[31];
            cc_q[chip_idx_q]        <= wr_code;
            if (wr_data[31]) begin
              icode_q[chip_idx_q] <= wr_code;
            end
          end
          REG_REF_INTV: ref_intv_q[chip_idx_q] <= wr_data;
          REG_REF_ROW:  ref_row_q[chip_idx_q] <= wr_data;
          REG_RAS_INTV: ras_intv_q[chip_idx_q] <= wr_data;
          REG_MIN_INTV: min_intv_q[chip_idx_q] <= wr_data;
          REG_ADDR_SEL: addr_sel_q[chip_idx_q] <= wr_data;
          default: ;
        endcase
      end
      if (cmd_i.ident) begin
        ident_q <= ident_calc;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q       <= (item_mode_q == MODE_READ || item_mode_q == MODE_WRITE) && find_hit;
      chip_idx_q  <= find_idx;
      read_data_q <= '0;
      thit_q      <= item_mode_q == MODE_XLATE && xl_hit;
      phys_q      <= (item_mode_q == MODE_XLATE && xl_hit) ?
                     {2'(xl_idx), addr_q[LOW_ADDR_W-1:0]} : '0;
    end
    if (cmd_i.exec && item_mode_q == MODE_READ && hit_q) begin
      read_data_q <= rd_value;
    end
  end

  assign read_data_o       = read_data_q;
  assign chip_hit_o        = hit_q;
  assign phys_offset_o     = phys_q;
  assign translate_hit_o   = thit_q;
  assign identity_mapped_o = ident_q;

endmodule

`default_nettype wire

// ===== sv/dram_chip_register_file.sv =====
// Top level of the DRAM chip register file: controller plus datapath.
// Depends on drcrf_pkg, drcrf_ctrl and drcrf_dp.
`default_nettype none

// Control register file for up to NUM_CHIPS DRAM chips. An item is taken when
// start is high while busy is low; it is a register read, a register write or
// a bus address translate, chosen by mode_i (the fourth code does nothing).
// Reads and writes address a chip by device ID, ignoring ID bit 0: the first
// present enabled chip that matches answers, and the first present disabled
// chip is tried too. Translate maps bus_address_i to chip * 2 MiB plus the low
// 21 address bits through the first enabled chip whose ID pair matches.
// The result goes out after the lookup and execute steps, and for a write that
// lands on a chip register (indexes 1 to 8) after an extra identity step that
// recomputes the identity-mapping flag; busy stays high until the result has
// gone out. The state machine walks lookup, execute, optional identity update
// and result, one step per cycle, so the next item can be taken in the cycle
// after the result. The result is marked by result_valid_o, high for a single
// cycle; the receiver cannot stall it, so capture it then. identity_mapped_o
// gives the flag after the item. Configuration writes (chip count at index 0,
// calibrated current-code threshold at index 1) are always taken (cfg_ready_o
// is tied high) and belong in idle periods only; other indexes are ignored.
// There is no clearing pass after reset.

module dram_chip_register_file import drcrf_pkg::*; #(
  parameter int unsigned NUM_CHIPS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Item handshake
  input  logic                  start,
  output logic                  busy,
  output logic                  result_valid_o,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Item fields
  input  logic [1:0]            mode_i,
  input  logic                  ri_active_i,
  input  logic [15:0]           chip_select_i,
  input  logic                  broadcast_i,
  input  logic [REG_IDX_W-1:0]  reg_index_i,
  input  logic [31:0]           write_data_i,
  input  logic [7:0]            repeat_length_i,
  input  logic [31:0]           bus_address_i,
  // Result fields
  output logic [31:0]           read_data_o,
  output logic                  chip_hit_o,
  output logic [PHYS_W-1:0]     phys_offset_o,
  output logic                  translate_hit_o,
  output logic                  identity_mapped_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // The user must write configuration only while idle; the block does not enforce it and always accepts it.
  assign cfg_ready_o = 1'b1;

  drcrf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .status_i       (dp_status),
    .cmd_o          (dp_cmd),
    .result_valid_o (result_valid_o)
  );

  drcrf_dp #(
    .NUM_CHIPS (NUM_CHIPS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (dp_cmd),
    .status_o          (dp_status),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .mode_i            (mode_i),
    .ri_active_i       (ri_active_i),
    .chip_select_i     (chip_select_i),
    .broadcast_i       (broadcast_i),
    .reg_index_i       (reg_index_i),
    .write_data_i      (write_data_i),
    .repeat_length_i   (repeat_length_i),
    .bus_address_i     (bus_address_i),
    .read_data_o       (read_data_o),
    .chip_hit_o        (chip_hit_o),
    .phys_offset_o     (phys_offset_o),
    .translate_hit_o   (translate_hit_o),
    .identity_mapped_o (identity_mapped_o)
  );

`ifndef SYNTHESIS
  // An accepted item holds the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // A result leaves only while an item is in flight, and frees the block after it.
  a_result_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  a_result_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> (!busy && !result_valid_o))
    else $error("block still busy after result");

  // A register access and a translate never both report a hit.
  a_hit_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(chip_hit_o && translate_hit_o))
    else $error("chip hit and translate hit together");
`endif

endmodule

`default_nettype wire
